FILE: rtl/scc_pkg.sv
// package: types, constants and a helper function for the steric clash checker
package scc_pkg;

  localparam int unsigned MaxLigandDef  = 64;
  localparam int unsigned MaxProteinDef = 4096;
  localparam int unsigned CoordW = 24;
  localparam int unsigned ElemW  = 7;
  localparam int unsigned FragW  = 8;
  localparam int unsigned BondW  = 6;
  localparam int unsigned ScaleW = 10;
  localparam int unsigned RadW   = 9;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned SqW    = 2 * DiffW;
  localparam int unsigned D2W    = SqW + 2;
  localparam int unsigned QW     = ScaleW + RadW + 1;
  localparam int unsigned PW     = 2 * QW;
  localparam int unsigned LimW   = PW - 16 + 1;

  typedef enum logic [FuncW-1:0] {
    FUNC_LOAD_LIG  = 3'd0,
    FUNC_LOAD_PROT = 3'd1,
    FUNC_LOAD_BOND = 3'd2,
    FUNC_RUN       = 3'd3,
    FUNC_CLEAR     = 3'd4
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTRA_SCALE = 1'd0,
    CFG_INTER_SCALE = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BCLR,
    ST_LI_RD,
    ST_LI_LAT,
    ST_LJ_RD,
    ST_LJ_CMP,
    ST_P_RD,
    ST_P_CMP,
    ST_WAIT,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       load_i;    // latch atom i from read data
    logic       mode_inter;
    logic       pipe_go;   // pair valid entering compare pipe
    logic       pipe_flush;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;   // pipe produced a clash this cycle
    logic busy;  // pipe holds pairs
  } dp_sts_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic [ElemW-1:0]  el;
  } atom_t;

  function automatic logic [RadW-1:0] radius_q8(input logic [ElemW-1:0] el);
    logic [RadW-1:0] r;
    case (el)
      7'd1:    r = 9'd282;
      7'd5:    r = 9'd492;
      7'd6:    r = 9'd435;
      7'd7:    r = 9'd397;
      7'd8:    r = 9'd389;
      7'd9:    r = 9'd376;
      7'd15:   r = 9'd461;
      7'd16:   r = 9'd461;
      7'd17:   r = 9'd448;
      7'd35:   r = 9'd468;
      7'd53:   r = 9'd507;
      default: r = 9'd428;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/scc_if.sv
// valid/ready channel interfaces for input and result beats
interface scc_in_if;
  logic                          valid;
  logic                          ready;
  logic [scc_pkg::FuncW-1:0]     func;
  logic signed [scc_pkg::CoordW-1:0] pos_x;
  logic signed [scc_pkg::CoordW-1:0] pos_y;
  logic signed [scc_pkg::CoordW-1:0] pos_z;
  logic [scc_pkg::ElemW-1:0]     element;
  logic [scc_pkg::FragW-1:0]     fragment;
  logic [scc_pkg::BondW-1:0]     bond_first;
  logic [scc_pkg::BondW-1:0]     bond_second;
  modport source (output valid, func, pos_x, pos_y, pos_z, element, fragment,
                  bond_first, bond_second, input ready);
  modport sink   (input valid, func, pos_x, pos_y, pos_z, element, fragment,
                  bond_first, bond_second, output ready);
endinterface

interface scc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] clash_code;
  logic       overflow;
  modport source (output valid, clash_code, overflow, input ready);
  modport sink   (input valid, clash_code, overflow, output ready);
endinterface

FILE: rtl/scc_datapath.sv
// datapath: squared distance and radius limit compare pipeline
module scc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scc_pkg::dp_cmd_t              cmd_i,
  input  scc_pkg::atom_t                rd_atom_i,
  input  logic [scc_pkg::ScaleW-1:0]    intra_scale_i,
  input  logic [scc_pkg::ScaleW-1:0]    inter_scale_i,
  output scc_pkg::dp_sts_t              sts_o
);
  import scc_pkg::*;

  atom_t a_q;
  logic [ScaleW-1:0] scale;

  // stage 1: differences and scaled radius sum
  logic signed [DiffW-1:0] dx_q, dy_q, dz_q;
  logic [QW-1:0] q_q;
  logic v1_q;
  // stage 2: squares and product
  logic [SqW-1:0] sx_q, sy_q, sz_q;
  logic [PW-1:0] p_q;
  logic v2_q;
  // stage 3: sum and limit
  logic [D2W-1:0] d2_q;
  logic [LimW-1:0] lim_q;
  logic v3_q;

  logic [RadW:0] rsum;
  logic [PW:0] p_rnd;

  assign scale = cmd_i.mode_inter ? inter_scale_i : intra_scale_i;
  assign rsum  = {1'b0, radius_q8(a_q.el)} + {1'b0, radius_q8(rd_atom_i.el)};
  assign p_rnd = {1'b0, p_q} + (PW+1)'(65535);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_i) begin
      a_q <= rd_atom_i;
    end
    dx_q <= DiffW'(signed'(a_q.x)) - DiffW'(signed'(rd_atom_i.x));
    dy_q <= DiffW'(signed'(a_q.y)) - DiffW'(signed'(rd_atom_i.y));
    dz_q <= DiffW'(signed'(a_q.z)) - DiffW'(signed'(rd_atom_i.z));
    q_q  <= QW'(scale) * QW'(rsum);
    sx_q <= SqW'(dx_q * dx_q);
    sy_q <= SqW'(dy_q * dy_q);
    sz_q <= SqW'(dz_q * dz_q);
    p_q  <= PW'(q_q) * PW'(q_q);
    d2_q <= D2W'(sx_q) + D2W'(sy_q) + D2W'(sz_q);
    lim_q <= p_rnd[PW:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (cmd_i.pipe_flush) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.pipe_go;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign sts_o.hit  = v3_q && ({1'b0, d2_q} < (D2W+1)'(lim_q));
  assign sts_o.busy = v1_q | v2_q | v3_q;
endmodule

FILE: rtl/scc_ctrl.sv
// controller: table loads, bond matrix, pair walk sequencing and result beat
module scc_ctrl #(
  parameter int unsigned MaxLigand  = scc_pkg::MaxLigandDef,
  parameter int unsigned MaxProtein = scc_pkg::MaxProteinDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  scc_in_if.sink                     in_if,
  scc_out_if.source                  out_if,
  input  logic [scc_pkg::ScaleW-1:0] intra_scale_i,
  input  logic [scc_pkg::ScaleW-1:0] inter_scale_i,
  output scc_pkg::dp_cmd_t           cmd_o,
  output scc_pkg::atom_t             rd_atom_o,
  input  scc_pkg::dp_sts_t           sts_i
);
  import scc_pkg::*;

  localparam int unsigned LAw = (MaxLigand > 1) ? $clog2(MaxLigand) : 1;
  localparam int unsigned PAw = (MaxProtein > 1) ? $clog2(MaxProtein) : 1;
  localparam int unsigned LCw = $clog2(MaxLigand + 1);
  localparam int unsigned PCw = $clog2(MaxProtein + 1);

  // memories
  atom_t              lig_mem [MaxLigand];
  logic [FragW-1:0]   frag_mem [MaxLigand];
  atom_t              prot_mem [MaxProtein];
  logic [MaxLigand-1:0] bond_mem [MaxLigand];

  atom_t lig_rd_q, prot_rd_q;
  logic [FragW-1:0] frag_rd_q, frag_i_q;
  logic [MaxLigand-1:0] bond_rd_q, bond_row_q;

  state_e state_q, state_d;
  logic [LCw-1:0] lig_cnt_q;
  logic [PCw-1:0] prot_cnt_q;
  logic ovf_q;
  logic [LCw-1:0] i_q, i_d;
  logic [PCw-1:0] j_q, j_d;
  logic intra_q, intra_d, inter_q, inter_d;
  logic [LAw-1:0] clr_q, clr_d;
  logic ov_valid_q;
  logic [1:0] ov_code_q;
  logic ov_ovf_q;

  logic acc, out_take;
  logic [LAw-1:0] lig_ra;
  logic [PAw-1:0] prot_ra;
  logic bond_we, bond_clr;
  logic [LAw-1:0] bond_wa;
  logic [MaxLigand-1:0] bond_wd;
  logic set_ovf;
  logic emit;
  logic skip_pair;
  logic b_ok;

  assign acc      = in_if.valid & in_if.ready;
  assign out_take = out_if.valid & out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE) && !ov_valid_q;

  assign b_ok = ({1'b0, in_if.bond_first} < (BondW+1)'(MaxLigand)) &&
                ({1'b0, in_if.bond_second} < (BondW+1)'(MaxLigand));

  // loads
  always_ff @(posedge clk_i) begin
    if (acc && func_e'(in_if.func) == FUNC_LOAD_LIG && lig_cnt_q < LCw'(MaxLigand)) begin
      lig_mem[lig_cnt_q[LAw-1:0]]  <= '{x: in_if.pos_x, y: in_if.pos_y, z: in_if.pos_z,
                                       el: in_if.element};
      frag_mem[lig_cnt_q[LAw-1:0]] <= in_if.fragment;
    end
    if (acc && func_e'(in_if.func) == FUNC_LOAD_PROT && prot_cnt_q < PCw'(MaxProtein)) begin
      prot_mem[prot_cnt_q[PAw-1:0]] <= '{x: in_if.pos_x, y: in_if.pos_y, z: in_if.pos_z,
                                        el: in_if.element};
    end
    if (bond_we) begin
      bond_mem[bond_wa] <= bond_wd;
    end
    lig_rd_q  <= lig_mem[lig_ra];
    frag_rd_q <= frag_mem[lig_ra];
    bond_rd_q <= bond_mem[lig_ra];
    prot_rd_q <= prot_mem[prot_ra];
  end

  // bond matrix: a bond load is a read-modify-write of two rows over cycles,
  // done by the bond state. both ends written with symmetric bits
  logic [1:0] bph_q, bph_d;
  logic [LAw-1:0] b1_q, b2_q;
  logic bpend_q;

  always_comb begin
    bond_we = 1'b0;
    bond_wa = b1_q;
    bond_wd = '0;
    bond_clr = (state_q == ST_BCLR);
    if (bond_clr) begin
      bond_we = 1'b1;
      bond_wa = clr_q;
    end else if (bpend_q && bph_q == 2'd2) begin
      bond_we = 1'b1;
      bond_wa = b1_q;
      bond_wd = bond_rd_q | (MaxLigand'(1) << b2_q);
    end else if (bpend_q && bph_q == 2'd3) begin
      bond_we = 1'b1;
      bond_wa = b2_q;
      bond_wd = bond_rd_q | (MaxLigand'(1) << b1_q);
    end
  end

  always_comb begin
    bph_d = bph_q;
    if (acc && func_e'(in_if.func) == FUNC_LOAD_BOND && b_ok) bph_d = '0;
    else if (bpend_q) bph_d = bph_q + 2'd1;
  end

  // read address choice
  always_comb begin
    lig_ra  = i_q[LAw-1:0];
    prot_ra = j_q[PAw-1:0];
    if (bpend_q) begin
      lig_ra = (bph_q[0] == 1'b1) ? b1_q : b2_q;
    end else if (state_q == ST_LJ_RD || state_q == ST_LJ_CMP) begin
      lig_ra = j_q[LAw-1:0];
    end
  end

  assign rd_atom_o = (state_q == ST_P_CMP) ? prot_rd_q : lig_rd_q;
  assign skip_pair = (frag_rd_q == frag_i_q) || bond_row_q[j_q[LAw-1:0]];

  // next state
  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    clr_d = clr_q;
    intra_d = intra_q | (sts_i.hit & ~cmd_o.mode_inter);
    inter_d = inter_q | (sts_i.hit &  cmd_o.mode_inter);
    emit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc && func_e'(in_if.func) == FUNC_RUN) begin
          state_d = ST_LI_RD;
          i_d = '0;
          intra_d = 1'b0;
          inter_d = 1'b0;
        end else if (acc && func_e'(in_if.func) == FUNC_CLEAR) begin
          state_d = ST_BCLR;
          clr_d = '0;
        end else if (acc && func_e'(in_if.func) == FUNC_LOAD_BOND && b_ok) begin
          state_d = ST_WAIT;
        end
      end
      ST_BCLR: begin
        clr_d = clr_q + LAw'(1);
        if (clr_q == LAw'(MaxLigand - 1)) state_d = ST_IDLE;
      end
      ST_WAIT: begin
        if (bph_q == 2'd3) state_d = ST_IDLE;
      end
      ST_LI_RD: begin
        if (i_q >= lig_cnt_q) state_d = ST_DONE;
        else state_d = ST_LI_LAT;
      end
      ST_LI_LAT: begin
        j_d = '0;
        state_d = ST_LJ_RD;
      end
      ST_LJ_RD: begin
        if (intra_d || intra_scale_i == '0 || PCw'(j_q) >= PCw'(i_q)) begin
          if (!sts_i.busy) begin
            j_d = '0;
            state_d = ST_P_RD;
          end
        end else begin
          state_d = ST_LJ_CMP;
        end
      end
      ST_LJ_CMP: begin
        j_d = j_q + PCw'(1);
        state_d = ST_LJ_RD;
      end
      ST_P_RD: begin
        if (inter_d || inter_scale_i == '0 || j_q >= prot_cnt_q) begin
          if (!sts_i.busy) begin
            i_d = i_q + LCw'(1);
            state_d = ST_LI_RD;
          end
        end else begin
          state_d = ST_P_CMP;
        end
      end
      ST_P_CMP: begin
        j_d = j_q + PCw'(1);
        state_d = ST_P_RD;
      end
      ST_DONE: begin
        emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.mode_inter = (state_q == ST_P_RD) || (state_q == ST_P_CMP);
    case (state_q)
      ST_LI_LAT: cmd_o.load_i = 1'b1;
      ST_LJ_CMP: cmd_o.pipe_go = ~skip_pair;
      ST_P_CMP:  cmd_o.pipe_go = 1'b1;
      ST_LI_RD:  cmd_o.pipe_flush = 1'b1;
      default: ;
    endcase
  end

  assign set_ovf = acc && (
      (func_e'(in_if.func) == FUNC_LOAD_LIG && lig_cnt_q >= LCw'(MaxLigand)) ||
      (func_e'(in_if.func) == FUNC_LOAD_PROT && prot_cnt_q >= PCw'(MaxProtein)) ||
      (func_e'(in_if.func) == FUNC_LOAD_BOND && !b_ok));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LI_LAT) begin
      frag_i_q   <= frag_rd_q;
      bond_row_q <= bond_rd_q;
    end
    if (acc) begin
      b1_q <= LAw'(in_if.bond_first);
      b2_q <= LAw'(in_if.bond_second);
    end
    if (emit) begin
      ov_code_q <= {intra_q, inter_q};
      ov_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BCLR;
      lig_cnt_q <= '0;
      prot_cnt_q <= '0;
      ovf_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      intra_q <= 1'b0;
      inter_q <= 1'b0;
      clr_q <= '0;
      ov_valid_q <= 1'b0;
      bph_q <= '0;
      bpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      intra_q <= intra_d;
      inter_q <= inter_d;
      clr_q <= clr_d;
      bph_q <= bph_d;
      if (acc && func_e'(in_if.func) == FUNC_LOAD_BOND && b_ok) begin
        bpend_q <= 1'b1;
      end else if (bpend_q && bph_q == 2'd3) begin
        bpend_q <= 1'b0;
      end
      if (acc && func_e'(in_if.func) == FUNC_LOAD_LIG && lig_cnt_q < LCw'(MaxLigand))
        lig_cnt_q <= lig_cnt_q + LCw'(1);
      if (acc && func_e'(in_if.func) == FUNC_LOAD_PROT && prot_cnt_q < PCw'(MaxProtein))
        prot_cnt_q <= prot_cnt_q + PCw'(1);
      if (set_ovf) ovf_q <= 1'b1;
      if (acc && func_e'(in_if.func) == FUNC_CLEAR) begin
        lig_cnt_q <= '0;
        prot_cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (emit) ov_valid_q <= 1'b1;
      else if (out_take) ov_valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = ov_valid_q;
  assign out_if.clash_code = ov_code_q;
  assign out_if.overflow   = ov_ovf_q;
endmodule

FILE: rtl/steric_clash_check.sv
// top level: steric clash checker
//  channel  dir  handshake      payload
//  in_if    in   valid/ready    func, pos_x/y/z, element, fragment, bond_first/second
//  out_if   out  valid/ready    clash_code, overflow
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
// a bond load updates two bond matrix rows; a clear sweeps every row
// a run fetches each ligand atom's row, walks its pairs through the single table read port
// and the 3-stage compare pipe, and drains the pipe twice per ligand atom
// reset empties counts and flags, then sweeps every row of the bond matrix
// input is stalled while a run, clear or bond update is in progress or a result waits
module steric_clash_check #(
  parameter int unsigned MaxLigand  = scc_pkg::MaxLigandDef,
  parameter int unsigned MaxProtein = scc_pkg::MaxProteinDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  scc_in_if.sink                       in_if,
  scc_out_if.source                    out_if,
  input  logic                         cfg_we_i,
  input  logic [scc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [scc_pkg::CfgDataW-1:0] cfg_data_i
);
  import scc_pkg::*;

  logic [ScaleW-1:0] intra_scale_q, inter_scale_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  atom_t rd_atom;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intra_scale_q <= '0;
      inter_scale_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INTRA_SCALE: intra_scale_q <= cfg_data_i;
        CFG_INTER_SCALE: inter_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scc_ctrl #(.MaxLigand(MaxLigand), .MaxProtein(MaxProtein)) u_ctrl (
    .clk_i, .rst_ni, .in_if, .out_if,
    .intra_scale_i(intra_scale_q), .inter_scale_i(inter_scale_q),
    .cmd_o(cmd), .rd_atom_o(rd_atom), .sts_i(sts)
  );

  scc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .rd_atom_i(rd_atom),
    .intra_scale_i(intra_scale_q), .inter_scale_i(inter_scale_q), .sts_o(sts)
  );
endmodule
